FILE: rtl/multi_channel_pipe_fifo_core_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the multi-channel pipe FIFO core
// Wraps concurrent assertions so that synthesis sees empty bodies.
// ---------------------------------------------------------------------------
`ifndef MULTI_CHANNEL_PIPE_FIFO_CORE_DEFINES_SVH
`define MULTI_CHANNEL_PIPE_FIFO_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define MCPF_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define MCPF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define MCPF_ASSERT_NOW(lbl, clk, rst, ante, cons, msg)
`define MCPF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

FILE: rtl/mcpf_pkg.sv
// ---------------------------------------------------------------------------
// mcpf_pkg
// Command and status codes and the request / result records of the core.
// ---------------------------------------------------------------------------
package mcpf_pkg;

  localparam logic [2:0] CMD_OPEN    = 3'd0;
  localparam logic [2:0] CMD_WRITE   = 3'd1;
  localparam logic [2:0] CMD_READ    = 3'd2;
  localparam logic [2:0] CMD_CLOSE_W = 3'd3;
  localparam logic [2:0] CMD_CLOSE_R = 3'd4;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_UNUSABLE = 3'd1;
  localparam logic [2:0] ST_BROKEN   = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_EMPTY    = 3'd4;
  localparam logic [2:0] ST_EOD      = 3'd5;

  typedef struct packed {
    logic [2:0] cmd;
    logic       anonymous;
    logic [3:0] pipe_id;
    logic [7:0] data_in;
    logic       request_end;
  } item_t;

  // result fields known at decode time; the read byte joins from the RAM
  typedef struct packed {
    logic [2:0] status;
    logic [3:0] pipe_out;
    logic       rd_ok;
    logic       request_end;
  } result_t;

endpackage

FILE: rtl/mcpf_ram.sv
// ---------------------------------------------------------------------------
// mcpf_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ---------------------------------------------------------------------------
module mcpf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/mcpf_ctrl.sv
// ---------------------------------------------------------------------------
// mcpf_ctrl
// Per-pipe state table and command decode; issues the byte store access.
// ---------------------------------------------------------------------------
module mcpf_ctrl #(
  parameter int PIPE_COUNT = 16,
  parameter int PIPE_DEPTH = 256,
  localparam int SW = (PIPE_COUNT > 1) ? $clog2(PIPE_COUNT) : 1,
  localparam int IW = $clog2(PIPE_DEPTH),
  localparam int MEM_AW = $clog2(PIPE_COUNT * (2 ** IW))
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  mcpf_pkg::item_t     item,
  output mcpf_pkg::result_t   res,
  output logic                mem_we,
  output logic [MEM_AW-1:0]   mem_waddr,
  output logic [7:0]          mem_wdata,
  output logic                mem_re,
  output logic [MEM_AW-1:0]   mem_raddr
);

  import mcpf_pkg::*;

  localparam int CW = $clog2(PIPE_DEPTH + 1);

  logic [PIPE_COUNT-1:0] used;
  logic [PIPE_COUNT-1:0] wclosed;
  logic [PIPE_COUNT-1:0] rclosed;
  logic [IW-1:0]         rd_idx [PIPE_COUNT];
  logic [IW-1:0]         wr_idx [PIPE_COUNT];
  logic [CW-1:0]         fill   [PIPE_COUNT];

  logic [SW+3:0] id_ext;
  logic [SW-1:0] sel;
  logic          id_valid;
  logic          used_sel;
  logic          free_found;
  logic [SW-1:0] free_idx;
  logic [SW+3:0] free_ext;
  logic [SW-1:0] open_slot;
  logic          do_open, do_write, do_read, do_close_w, do_close_r;
  logic [IW-1:0] wr_cur, rd_cur, wr_next, rd_next;
  logic [CW-1:0] fill_cur;
  logic [SW+IW-1:0] waddr_full, raddr_full;

  assign id_ext   = {{SW{1'b0}}, item.pipe_id};
  assign sel      = id_ext[SW-1:0];
  assign id_valid = id_ext < (SW + 4)'(PIPE_COUNT);
  assign used_sel = id_valid && used[sel];
  assign wr_cur   = wr_idx[sel];
  assign rd_cur   = rd_idx[sel];
  assign fill_cur = fill[sel];
  assign wr_next  = (wr_cur == IW'(PIPE_DEPTH - 1)) ? '0 : wr_cur + IW'(1);
  assign rd_next  = (rd_cur == IW'(PIPE_DEPTH - 1)) ? '0 : rd_cur + IW'(1);

  // lowest free slot wins
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = PIPE_COUNT - 1; i >= 0; i--) begin
      if (!used[i]) begin
        free_found = 1'b1;
        free_idx   = SW'(i);
      end
    end
  end
  assign free_ext = {4'b0, free_idx};

  always_comb begin
    res.status      = ST_UNUSABLE;
    res.pipe_out    = item.pipe_id;
    res.rd_ok       = 1'b0;
    res.request_end = item.request_end;
    do_open    = 1'b0;
    do_write   = 1'b0;
    do_read    = 1'b0;
    do_close_w = 1'b0;
    do_close_r = 1'b0;
    open_slot  = sel;
    case (item.cmd)
      CMD_OPEN: begin
        if (item.anonymous) begin
          res.pipe_out = '0;
          if (free_found) begin
            do_open      = 1'b1;
            open_slot    = free_idx;
            res.pipe_out = free_ext[3:0];
            res.status   = ST_OK;
          end
        end else if (id_valid) begin
          do_open    = !used[sel];
          res.status = ST_OK;
        end
      end
      CMD_WRITE: begin
        if (used_sel) begin
          if (rclosed[sel]) begin
            res.status = ST_BROKEN;
          end else if (fill_cur >= CW'(PIPE_DEPTH)) begin
            res.status = ST_FULL;
          end else begin
            do_write   = 1'b1;
            res.status = ST_OK;
          end
        end
      end
      CMD_READ: begin
        if (used_sel) begin
          if (fill_cur == '0) begin
            res.status = wclosed[sel] ? ST_EOD : ST_EMPTY;
          end else begin
            do_read    = 1'b1;
            res.rd_ok  = 1'b1;
            res.status = ST_OK;
          end
        end
      end
      CMD_CLOSE_W: begin
        if (used_sel) begin
          do_close_w = 1'b1;
          res.status = ST_OK;
        end
      end
      CMD_CLOSE_R: begin
        if (used_sel) begin
          do_close_r = 1'b1;
          res.status = ST_OK;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used    <= '0;
      wclosed <= '0;
      rclosed <= '0;
      for (int i = 0; i < PIPE_COUNT; i++) begin
        rd_idx[i] <= '0;
        wr_idx[i] <= '0;
        fill[i]   <= '0;
      end
    end else if (fire) begin
      if (do_open) begin
        used[open_slot]    <= 1'b1;
        wclosed[open_slot] <= 1'b0;
        rclosed[open_slot] <= 1'b0;
        rd_idx[open_slot]  <= '0;
        wr_idx[open_slot]  <= '0;
        fill[open_slot]    <= '0;
      end
      if (do_write) begin
        wr_idx[sel] <= wr_next;
        fill[sel]   <= fill_cur + CW'(1);
      end
      if (do_read) begin
        rd_idx[sel] <= rd_next;
        fill[sel]   <= fill_cur - CW'(1);
      end
      if (do_close_w) begin
        wclosed[sel] <= 1'b1;
        if (rclosed[sel]) begin
          used[sel] <= 1'b0;
        end
      end
      if (do_close_r) begin
        rclosed[sel] <= 1'b1;
        if (wclosed[sel]) begin
          used[sel] <= 1'b0;
        end
      end
    end
  end

  assign waddr_full = {sel, wr_cur};
  assign raddr_full = {sel, rd_cur};
  assign mem_we     = fire && do_write;
  assign mem_waddr  = waddr_full[MEM_AW-1:0];
  assign mem_wdata  = item.data_in;
  assign mem_re     = fire && do_read;
  assign mem_raddr  = raddr_full[MEM_AW-1:0];

endmodule

FILE: rtl/multi_channel_pipe_fifo_core.sv
// Stages: input register, then result register alongside the registered
//   byte store read.
// Throughput: 1 request per cycle unless the result channel stalls; the
//   per-pipe state table and the single write / single read port of the byte store each serve one access a cycle.
// Reset: rst (synchronous, active high) closes all pipes and empties both
//   stages; the byte store is not cleared, no pipe can reach stale bytes.
// ---------------------------------------------------------------------------
// multi_channel_pipe_fifo_core
// Bank of byte pipes kept as ring buffers in one shared byte store. Each
// request opens, writes, reads or closes one pipe and yields one result.
// ---------------------------------------------------------------------------
`include "multi_channel_pipe_fifo_core_defines.svh"

module multi_channel_pipe_fifo_core #(
  parameter int PIPE_COUNT = 16,
  parameter int PIPE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [2:0] cmd, [3] anonymous, [7:4] pipe_id, [15:8] data_in
  input  logic [15:0] s_axis_tdata,
  input  logic        s_axis_tlast,   // request_end
  // result channel
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [2:0] status, [6:3] pipe_out, [14:7] data_out, [15] zero
  output logic [15:0] m_axis_tdata,
  output logic        m_axis_tlast    // request_end_out
);

  import mcpf_pkg::*;

  localparam int IW     = $clog2(PIPE_DEPTH);
  localparam int MEM_DEPTH = PIPE_COUNT * (2 ** IW);
  localparam int MEM_AW = $clog2(MEM_DEPTH);

  // input register
  logic    s1_valid;
  item_t   item;
  // result register
  logic    s2_valid;
  result_t res_q;

  logic    advance;
  logic    fire;
  result_t res;

  logic              mem_we, mem_re;
  logic [MEM_AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]        mem_wdata, mem_rdata;
  logic [7:0]        data_out;

  // Advance whenever the result register is free or being drained. The
  // whole pipe holds together on a stall, so the RAM read data holds too.
  assign advance       = !s2_valid || m_axis_tready;
  assign fire          = s1_valid && advance;
  assign s_axis_tready = advance || !s1_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  // capture the request fields; payload needs no reset
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item.cmd         <= s_axis_tdata[2:0];
      item.anonymous   <= s_axis_tdata[3];
      item.pipe_id     <= s_axis_tdata[7:4];
      item.data_in     <= s_axis_tdata[15:8];
      item.request_end <= s_axis_tlast;
    end
  end

  // decode, update the pipe table and drive the byte store
  mcpf_ctrl #(
    .PIPE_COUNT (PIPE_COUNT),
    .PIPE_DEPTH (PIPE_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .item      (item),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr)
  );

  // one region of PIPE_DEPTH (rounded up to a power of two) bytes per pipe
  mcpf_ram #(
    .WIDTH (8),
    .DEPTH (MEM_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_q <= res;
    end
  end

  // the byte from the store only counts on a successful read
  assign data_out      = res_q.rd_ok ? mem_rdata : 8'd0;
  assign m_axis_tvalid = s2_valid;
  assign m_axis_tdata  = {1'b0, data_out, res_q.pipe_out, res_q.status};
  assign m_axis_tlast  = res_q.request_end;

  `MCPF_ASSERT_NEXT(a_fire_to_result, clk, rst, fire, m_axis_tvalid,
    "processed request did not reach the result register")
  `MCPF_ASSERT_NEXT(a_stall_holds_item, clk, rst, s1_valid && !advance,
    s1_valid && $stable(item), "stalled request lost or changed")
  `MCPF_ASSERT_NOW(a_rd_ok_status, clk, rst, s2_valid && res_q.rd_ok,
    res_q.status == ST_OK, "read data flagged on a failed request")
  `MCPF_ASSERT_NOW(a_data_zero, clk, rst, s2_valid && !res_q.rd_ok,
    m_axis_tdata[14:7] == 8'd0, "data_out nonzero without a read")

endmodule
